FILE: rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes of the double-ended queue: request and response
// layouts, operation and status codes, and the cell commands.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD       = 2'd0,
    CMD_SHIFT_UP   = 2'd1,
    CMD_SHIFT_DOWN = 2'd2,
    CMD_LOAD_AT    = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [WORD_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  back_value;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
    status_t                   status;
  } rsp_t;

endpackage

FILE: rtl/core/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of the deque chain. Shifts toward either neighbor, loads
// the request word at its own position, and drives its word onto the back
// readout tap when it holds the tail.
// ----------------------------------------------------------------------------
module dq_cell
  import dq_pkg::*;
#(
  parameter int DW  = 32,
  parameter int AW  = 4,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [AW-1:0] load_idx,
  input  logic [DW-1:0] word,
  input  logic [DW-1:0] prev_data,
  input  logic [DW-1:0] next_data,
  input  logic [AW-1:0] tail_idx,
  input  logic          occupied,
  output logic [DW-1:0] data,
  output logic [DW-1:0] tap
);

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_SHIFT_UP: begin
        data <= prev_data;
      end
      CMD_SHIFT_DOWN: begin
        data <= next_data;
      end
      CMD_LOAD_AT: begin
        if (load_idx == AW'(IDX)) begin
          data <= word;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

  assign tap = (occupied && (tail_idx == AW'(IDX))) ? data : '0;

endmodule

FILE: rtl/core/dq_or_tree.sv
// ----------------------------------------------------------------------------
// dq_or_tree
// Registered OR reduction of the cell taps. At most one tap is nonzero at a
// time, so the root carries the tail word, registered once per tree level.
// ----------------------------------------------------------------------------
module dq_or_tree
  import dq_pkg::*;
#(
  parameter int DW     = 32,
  parameter int LEAVES = 16
) (
  input  logic          clk,
  input  logic [DW-1:0] leaf [LEAVES],
  output logic [DW-1:0] root
);

  localparam int NODES = LEAVES - 1;

  logic [DW-1:0] node [NODES];

  for (genvar n = 0; n < NODES; n++) begin : g_node
    localparam int CL = 2 * n + 1;
    localparam int CR = 2 * n + 2;
    logic [DW-1:0] lhs;
    logic [DW-1:0] rhs;

    if (CL >= NODES) begin : g_l_leaf
      assign lhs = leaf[CL-NODES];
    end else begin : g_l_node
      assign lhs = node[CL];
    end

    if (CR >= NODES) begin : g_r_leaf
      assign rhs = leaf[CR-NODES];
    end else begin : g_r_node
      assign rhs = node[CR];
    end

    always_ff @(posedge clk) begin
      node[n] <= lhs | rhs;
    end
  end

  assign root = node[0];

endmodule

FILE: rtl/core/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Takes a new request only after the response to the previous one is loaded;
// the wait is set by the registered OR tree that reads the tail word out of
// the cell chain, and by a stalled response.
// Reset clears the count and control; cell contents stay undefined.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
  import dq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int LEAVES = 1 << $clog2(DEPTH);
  localparam int LVL    = $clog2(LEAVES);
  localparam int LVL_W  = $clog2(LVL + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [LVL_W-1:0]    wait_cnt;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [AW-1:0]       tail_idx;
  logic                occupied;
  status_t             status;
  status_t             status_next;

  cell_cmd_t           cmd;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] cdata [DEPTH];
  logic [DATA_WIDTH-1:0] leaf  [LEAVES];
  logic [DATA_WIDTH-1:0] back_word;

  logic                accept;
  logic                full;
  logic                load_rsp;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(DEPTH));
  assign word      = DATA_WIDTH'($unsigned(req_data.value));
  assign load_rsp  = (state == S_DRAIN) && (wait_cnt == '0) && (!rsp_valid || rsp_ready);

  always_comb begin
    cmd         = CMD_HOLD;
    count_next  = count;
    status_next = ST_DONE;
    case (req_data.operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_next = ST_PUSH_FULL;
        end else begin
          if (req_data.operation == OP_PUSH_FRONT) begin
            cmd = CMD_SHIFT_UP;
          end else begin
            cmd = CMD_LOAD_AT;
          end
          count_next = count + CW'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (count == '0) begin
          status_next = ST_POP_EMPTY;
        end else begin
          if (req_data.operation == OP_POP_FRONT) begin
            cmd = CMD_SHIFT_DOWN;
          end else begin
            cmd = CMD_HOLD;
          end
          count_next = count - CW'(1);
        end
      end
      default: begin
        cmd = CMD_HOLD;
      end
    endcase
    if (!accept) begin
      cmd = CMD_HOLD;
    end
  end

  for (genvar i = 0; i < LEAVES; i++) begin : g_cell
    if (i < DEPTH) begin : g_live
      logic [DATA_WIDTH-1:0] prev_d;
      logic [DATA_WIDTH-1:0] next_d;

      if (i == 0) begin : g_head
        assign prev_d = word;
      end else begin : g_mid_p
        assign prev_d = cdata[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign next_d = '0;
      end else begin : g_mid_n
        assign next_d = cdata[i+1];
      end

      dq_cell #(
        .DW  (DATA_WIDTH),
        .AW  (AW),
        .IDX (i)
      ) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .load_idx  (AW'(count)),
        .word      (word),
        .prev_data (prev_d),
        .next_data (next_d),
        .tail_idx  (tail_idx),
        .occupied  (occupied),
        .data      (cdata[i]),
        .tap       (leaf[i])
      );
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  dq_or_tree #(
    .DW     (DATA_WIDTH),
    .LEAVES (LEAVES)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (back_word)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wait_cnt  <= '0;
      count     <= '0;
      occupied  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        wait_cnt <= LVL_W'(LVL);
        count    <= count_next;
        occupied <= (count_next != '0);
      end else if (wait_cnt != '0) begin
        wait_cnt <= wait_cnt - LVL_W'(1);
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tail_idx <= AW'(count_next - CW'(1));
      status   <= status_next;
    end
    if (load_rsp) begin
      rsp_data.front_value <= occupied ? WORD_W'($unsigned(cdata[0])) : '0;
      rsp_data.back_value  <= WORD_W'($unsigned(back_word));
      rsp_data.count       <= COUNT_W'(count);
      rsp_data.is_empty    <= !occupied;
      rsp_data.status      <= status;
    end
  end

endmodule

FILE: rtl/core/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks on the deque: response hold under stall, one request in
// flight at a time, and consistency of the empty and error reporting.
// ----------------------------------------------------------------------------
module dq_checker
  import dq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req_data,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.is_empty |->
      rsp_data.front_value == '0 && rsp_data.back_value == '0)
    else $error("empty deque reports a nonzero word");

  a_pop_err_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_POP_EMPTY |-> rsp_data.is_empty)
    else $error("pop refused on a non-empty deque");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.status != ST_RSVD)
    else $error("reserved status code");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (.*);
